// ----- hw/rtl/mkdb_pkg.sv -----
// Shared types and constants for the multi-key debouncer with short and long press events.
package mkdb_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int HELD_W = 16;
  localparam int CNT_W = 4;
  localparam int FIELD_W = 3;

  localparam logic [HELD_W-1:0] HELD_MAX = 16'd60000;

  localparam logic [2:0] RST_ACTIVE_LEVELS = 3'd0;
  localparam logic [3:0] RST_DEBOUNCE_LIMIT = 4'd2;
  localparam logic [15:0] RST_LONG_PRESS_TICKS = 16'd100;

  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [FIELD_W-1:0] EVT_NONE = 3'd0;

  typedef enum logic [1:0] {
    REG_ACTIVE_LEVELS = 2'd0,
    REG_DEBOUNCE_LIMIT = 2'd1,
    REG_LONG_PRESS_TICKS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] active_levels;
    logic [CNT_W-1:0] debounce_limit;
    logic [HELD_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic level;
    logic short_ev;
    logic long_ev;
  } key_status_t;

endpackage

// ----- hw/rtl/mkdb_cfg.sv -----
// Register file for the debouncer settings behind an APB-style port.
module mkdb_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mkdb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mkdb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mkdb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output mkdb_pkg::cfg_t                  cfg
);
  import mkdb_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_levels <= RST_ACTIVE_LEVELS;
      cfg_r.debounce_limit <= RST_DEBOUNCE_LIMIT;
      cfg_r.long_press_ticks <= RST_LONG_PRESS_TICKS;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_LEVELS: cfg_r.active_levels <= pwdata[2:0];
        REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= pwdata[CNT_W-1:0];
        REG_LONG_PRESS_TICKS: cfg_r.long_press_ticks <= pwdata[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_LEVELS: prdata = {29'd0, cfg_r.active_levels};
      REG_DEBOUNCE_LIMIT: prdata = {28'd0, cfg_r.debounce_limit};
      REG_LONG_PRESS_TICKS: prdata = {16'd0, cfg_r.long_press_ticks};
      default: prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/mkdb_key.sv -----
// Debounce and press-duration tracking for a single key.
module mkdb_key (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 pressed,
  input  mkdb_pkg::cfg_t       cfg,
  output mkdb_pkg::key_status_t status
);
  import mkdb_pkg::*;

  logic              samp_r, samp_nxt;
  logic              deb_r, deb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HELD_W-1:0] held_r, held_nxt, held_mid;
  logic              ld_r, ld_nxt, ld_mid;
  logic              short_ev, long_ev;

  always_comb begin
    samp_nxt = samp_r;
    deb_nxt = deb_r;
    cnt_nxt = cnt_r;
    held_mid = held_r;
    ld_mid = ld_r;
    short_ev = 1'b0;
    if (pressed != samp_r) begin
      samp_nxt = pressed;
      cnt_nxt = '0;
    end else if (cnt_r < cfg.debounce_limit) begin
      cnt_nxt = cnt_r + 4'd1;
    end else if (deb_r != samp_r) begin
      deb_nxt = samp_r;
      if (samp_r) begin
        held_mid = '0;
        ld_mid = 1'b0;
      end else if (!ld_r && (held_r < cfg.long_press_ticks)) begin
        short_ev = 1'b1;
      end
    end

    held_nxt = held_mid;
    ld_nxt = ld_mid;
    long_ev = 1'b0;
    if (deb_nxt) begin
      if (held_mid < HELD_MAX) begin
        held_nxt = held_mid + 16'd1;
      end
      if (!ld_mid && (held_nxt >= cfg.long_press_ticks)) begin
        ld_nxt = 1'b1;
        long_ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= 1'b0;
      deb_r <= 1'b0;
      cnt_r <= '0;
      held_r <= '0;
      ld_r <= 1'b0;
    end else if (step) begin
      samp_r <= samp_nxt;
      deb_r <= deb_nxt;
      cnt_r <= cnt_nxt;
      held_r <= held_nxt;
      ld_r <= ld_nxt;
    end
  end

  assign status.level = step ? deb_nxt : deb_r;
  assign status.short_ev = step && short_ev;
  assign status.long_ev = step && long_ev;

endmodule

// ----- hw/rtl/multi_key_debounce_short_long_press_core.sv -----
// Top level of the multi-key debouncer: input register, per-key units, event slot, result register.
// Each transfer on the input channel is one item: a scan tick carrying the raw pin levels, or a
// fetch that returns and clears the pending event. Every item produces exactly one result once it
// has passed through the input register and then the result register, and a new item can be
// taken in every cycle; the input side stalls only when both the input register and the result
// register are full and the result side stalls. All per-key work (debounce count, held tick
// count, event decision) and the event slot update happen in one pass of logic between those two
// registers. The user must write settings through the APB-style port only while the block is
// idle; the block itself does not enforce it.
module multi_key_debounce_short_long_press_core #(
  parameter int NUM_KEYS = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [mkdb_pkg::FIELD_W-1:0]    in_pin_levels,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mkdb_pkg::FIELD_W-1:0]    out_event_code,
  output logic [mkdb_pkg::FIELD_W-1:0]    out_stable_keys,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mkdb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mkdb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mkdb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mkdb_pkg::*;

  cfg_t cfg;

  logic               in_valid_r;
  logic               action_r;
  logic [FIELD_W-1:0] pins_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] code_r, code_nxt;
  logic [FIELD_W-1:0] stable_r, stable_nxt;
  logic [FIELD_W-1:0] pending_r, pending_nxt;

  logic out_adv;
  logic in_load;
  logic work;
  logic scan;

  logic [NUM_KEYS+FIELD_W-1:0] pins_pad;
  logic [NUM_KEYS+FIELD_W-1:0] act_pad;
  logic [NUM_KEYS-1:0]         pressed;
  logic [NUM_KEYS-1:0]         level_vec;
  logic [NUM_KEYS+FIELD_W-1:0] level_pad;
  key_status_t                 status [NUM_KEYS];
  logic [FIELD_W-1:0]          evt_code;
  logic                        evt_found;

  mkdb_cfg u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  assign out_adv = !out_valid_r || !out_stall;
  assign in_load = !in_valid_r || out_adv;
  assign in_stall = !in_load;
  assign work = in_valid_r && out_adv;
  assign scan = work && (action_r == ACT_SCAN);

  assign pins_pad = {{NUM_KEYS{1'b0}}, pins_r};
  assign act_pad = {{NUM_KEYS{1'b0}}, cfg.active_levels};

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    assign pressed[k] = (pins_pad[k] == act_pad[k]);

    mkdb_key u_key (
      .clk(clk),
      .rst_n(rst_n),
      .step(scan),
      .pressed(pressed[k]),
      .cfg(cfg),
      .status(status[k])
    );

    assign level_vec[k] = status[k].level;
  end

  always_comb begin
    evt_code = EVT_NONE;
    evt_found = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!evt_found && status[k].short_ev) begin
        evt_code = FIELD_W'(2 * k + 1);
        evt_found = 1'b1;
      end else if (!evt_found && status[k].long_ev) begin
        evt_code = FIELD_W'(2 * k + 2);
        evt_found = 1'b1;
      end
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    code_nxt = EVT_NONE;
    if (work && (action_r == ACT_FETCH)) begin
      code_nxt = pending_r;
      pending_nxt = EVT_NONE;
    end else if (scan && (pending_r == EVT_NONE) && evt_found) begin
      pending_nxt = evt_code;
    end
  end

  // The key units present their debounced levels as they stand after the current scan.
  assign level_pad = {{FIELD_W{1'b0}}, level_vec};
  assign stable_nxt = level_pad[FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r <= EVT_NONE;
    end else begin
      if (in_load) begin
        in_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      action_r <= in_action;
      pins_r <= in_pin_levels;
    end
    if (work) begin
      code_r <= code_nxt;
      stable_r <= stable_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_code = code_r;
  assign out_stable_keys = stable_r;

  a_scan_gives_no_code : assert property (
    @(posedge clk) disable iff (!rst_n)
    (work && (action_r == ACT_SCAN)) |=> (out_event_code == EVT_NONE)
  ) else $error("scan item produced a nonzero event code");

  a_fetch_clears_slot : assert property (
    @(posedge clk) disable iff (!rst_n)
    (work && (action_r == ACT_FETCH)) |=> (pending_r == EVT_NONE)
  ) else $error("fetch did not clear the event slot");

  a_slot_holds_first : assert property (
    @(posedge clk) disable iff (!rst_n)
    ((pending_r != EVT_NONE) && !(work && (action_r == ACT_FETCH)))
      |=> (pending_r == $past(pending_r))
  ) else $error("pending event was overwritten");

  a_stall_only_when_full : assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall)
  ) else $error("input stalled while the pipeline had room");

endmodule
